@@ src/gfns_pkg.sv @@
package gfns_pkg;

	// default number of node records held
	localparam int MAX_NODES_DEF = 128;

	// room count after reset
	localparam logic [7:0] ROOM_COUNT_RST = 8'd100;

	// input command codes (carried on tuser)
	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	// largest distance the result field can show
	localparam int OUT_DIST_MAX = 127;

	// one node record: exit bits N, S, E, W from bit 0 up, one target per exit
	typedef struct packed {
		logic [3:0][6:0] target;
		logic [3:0]      exit_mask;
	} node_rec_t;

	// one search result
	typedef struct packed {
		logic [6:0] distance;
		logic [6:0] node;
	} result_t;

endpackage

@@ src/gfns_node_mem.sv @@
module gfns_node_mem
	import gfns_pkg::*;
#(
	parameter int MAX_NODES = MAX_NODES_DEF,
	localparam int IW = $clog2(MAX_NODES)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [IW-1:0] waddr,
	input  node_rec_t     wdata,
	input  logic          re,
	input  logic [IW-1:0] raddr,
	output node_rec_t     rdata
);

	node_rec_t mem [MAX_NODES];
	node_rec_t rdata_q;

	// record write from a load transfer
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, held between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/gfns_visit_queue.sv @@
module gfns_visit_queue
	import gfns_pkg::*;
#(
	parameter int MAX_NODES = MAX_NODES_DEF,
	localparam int IW = $clog2(MAX_NODES),
	localparam int QW = 2 * IW
) (
	input  logic          clk,
	input  logic          we,
	input  logic [IW-1:0] waddr,
	input  logic [QW-1:0] wdata,
	input  logic          re,
	input  logic [IW-1:0] raddr,
	output logic [QW-1:0] rdata
);

	// each entry holds {distance, node}
	logic [QW-1:0] mem [MAX_NODES];
	logic [QW-1:0] rdata_q;

	// push at the tail
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// pop at the head, registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/gfns_search.sv @@
module gfns_search
	import gfns_pkg::*;
#(
	parameter int MAX_NODES = MAX_NODES_DEF,
	localparam int IW = $clog2(MAX_NODES),
	localparam int CW = $clog2(MAX_NODES + 1),
	localparam int QW = 2 * IW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [CW-1:0] nodes_in_use,
	// input transfer side
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          in_cmd,
	input  logic [6:0]    in_index,
	input  node_rec_t     in_rec,
	// node record memory
	output logic          nm_we,
	output logic [IW-1:0] nm_waddr,
	output node_rec_t     nm_wdata,
	output logic          nm_re,
	output logic [IW-1:0] nm_raddr,
	input  node_rec_t     nm_rdata,
	// visit queue memory
	output logic          q_we,
	output logic [IW-1:0] q_waddr,
	output logic [QW-1:0] q_wdata,
	output logic          q_re,
	output logic [IW-1:0] q_raddr,
	input  logic [QW-1:0] q_rdata,
	// result side
	output logic          res_valid,
	input  logic          res_ready,
	output result_t       res
);

	localparam int DW = IW;
	localparam int TW = (CW > 7) ? CW : 7;
	localparam int XW = (IW > 7) ? IW : 7;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RDQ  = 3'd1;
	localparam logic [2:0] ST_RDN  = 3'd2;
	localparam logic [2:0] ST_EXIT = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]           state_q;
	logic [CW-1:0]        head_q;
	logic [CW-1:0]        tail_q;
	logic [MAX_NODES-1:0] visited_q;
	logic [1:0]           dir_q;
	logic [DW-1:0]        cur_dist_q;
	logic [IW-1:0]        best_node_q;
	logic [DW-1:0]        best_dist_q;

	logic          accept;
	logic          start;
	logic [TW-1:0] n_w;
	logic [6:0]    tgt;
	logic [IW-1:0] tgt_addr;
	logic          follow;
	logic [DW-1:0] new_dist;
	logic          better;
	logic [XW-1:0] best_node_x;
	logic [XW-1:0] best_dist_x;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign start    = accept && (in_cmd == CMD_SEARCH);
	assign n_w      = TW'(nodes_in_use);

	// load path: drop records at or above the nodes-in-use count
	assign nm_we    = accept && (in_cmd == CMD_LOAD) && (TW'(in_index) < n_w);
	assign nm_waddr = IW'(in_index);
	assign nm_wdata = in_rec;

	// pop the queue head, then fetch that node's record
	assign q_re     = (state_q == ST_RDQ) && (head_q != tail_q);
	assign q_raddr  = head_q[IW-1:0];
	assign nm_re    = (state_q == ST_RDN);
	assign nm_raddr = q_rdata[IW-1:0];

	// one exit a cycle, in order north, south, east, west
	assign tgt      = nm_rdata.target[dir_q];
	assign tgt_addr = IW'(tgt);
	assign follow   = (state_q == ST_EXIT) && nm_rdata.exit_mask[dir_q] &&
		(TW'(tgt) < n_w) && !visited_q[tgt_addr];
	assign new_dist = cur_dist_q + DW'(1);
	assign better   = (new_dist > best_dist_q) ||
		((new_dist == best_dist_q) && (tgt_addr < best_node_q));

	// push node 0 at search start, else a newly reached node
	always_comb begin
		q_we    = start || follow;
		q_waddr = start ? '0 : tail_q[IW-1:0];
		q_wdata = start ? '0 : {new_dist, tgt_addr};
	end

	// result, distance saturated to the field range
	assign best_node_x  = XW'(best_node_q);
	assign best_dist_x  = XW'(best_dist_q);
	assign res_valid    = (state_q == ST_DONE);
	assign res.node     = best_node_x[6:0];
	assign res.distance = (best_dist_x > XW'(OUT_DIST_MAX)) ? 7'(OUT_DIST_MAX) :
		best_dist_x[6:0];

	// search sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			visited_q   <= '0;
			dir_q       <= '0;
			cur_dist_q  <= '0;
			best_node_q <= '0;
			best_dist_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						visited_q   <= {{(MAX_NODES - 1){1'b0}}, 1'b1};
						head_q      <= '0;
						tail_q      <= CW'(1);
						best_node_q <= '0;
						best_dist_q <= '0;
						state_q     <= ST_RDQ;
					end
				end
				ST_RDQ: begin
					if (head_q == tail_q) begin
						state_q <= ST_DONE;
					end else begin
						head_q  <= head_q + CW'(1);
						state_q <= ST_RDN;
					end
				end
				ST_RDN: begin
					cur_dist_q <= q_rdata[QW-1:IW];
					dir_q      <= '0;
					state_q    <= ST_EXIT;
				end
				ST_EXIT: begin
					if (follow) begin
						visited_q[tgt_addr] <= 1'b1;
						tail_q              <= tail_q + CW'(1);
						if (better) begin
							best_node_q <= tgt_addr;
							best_dist_q <= new_dist;
						end
					end
					dir_q <= dir_q + 2'd1;
					if (dir_q == 2'd3) begin
						state_q <= ST_RDQ;
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ src/graph_farthest_node_search.sv @@
// channel    dir  fields (low bit up)
// s_axis     in   tuser: cmd; tdata: node_index, exit_mask, north/south/east/west_target
// m_axis     out  tdata: farthest_node, farthest_distance
// cfg        in   cfg_we / cfg_wdata: room_count, no read-back
//
// loads are taken one per cycle while no search runs; a search walks each
// reachable node in turn: a queue read, then a record read, then one exit a cycle.
// reset clears control and sets room_count to 100; node records stay undefined.
// s_axis_tready is low while a search runs or its result waits for the output
// register; loads go on while a result sits unread on m_axis.
module graph_farthest_node_search
	import gfns_pkg::*;
#(
	parameter int MAX_NODES = MAX_NODES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,      // room_count
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // node_index, exit_mask, north, south, east, west
	input  logic        s_axis_tuser,   // cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata    // farthest_node, farthest_distance
);

	localparam int IW = $clog2(MAX_NODES);
	localparam int CW = $clog2(MAX_NODES + 1);
	localparam int QW = 2 * IW;
	localparam logic [8:0] MAX9 = 9'(MAX_NODES);

	logic [7:0]    room_count_q;
	logic [8:0]    rc9;
	logic [8:0]    n9;
	logic [CW-1:0] nodes_in_use;
	node_rec_t     in_rec;

	logic          nm_we;
	logic [IW-1:0] nm_waddr;
	node_rec_t     nm_wdata;
	logic          nm_re;
	logic [IW-1:0] nm_raddr;
	node_rec_t     nm_rdata;
	logic          q_we;
	logic [IW-1:0] q_waddr;
	logic [QW-1:0] q_wdata;
	logic          q_re;
	logic [IW-1:0] q_raddr;
	logic [QW-1:0] q_rdata;
	logic          res_valid;
	logic          res_ready;
	result_t       res;

	logic          out_valid_q;
	result_t       out_q;

	// room count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			room_count_q <= ROOM_COUNT_RST;
		end else if (cfg_we) begin
			room_count_q <= cfg_wdata;
		end
	end

	// nodes in use: zero counts as one, capped at the store depth
	assign rc9 = {1'b0, room_count_q};
	assign n9  = (rc9 == 9'd0) ? 9'd1 : ((rc9 > MAX9) ? MAX9 : rc9);
	assign nodes_in_use = CW'(n9);

	// unpack the input record
	assign in_rec.exit_mask = s_axis_tdata[10:7];
	assign in_rec.target[0] = s_axis_tdata[17:11];
	assign in_rec.target[1] = s_axis_tdata[24:18];
	assign in_rec.target[2] = s_axis_tdata[31:25];
	assign in_rec.target[3] = s_axis_tdata[38:32];

	gfns_search #(
		.MAX_NODES(MAX_NODES)
	) u_search (
		.clk         (clk),
		.arst_n      (arst_n),
		.nodes_in_use(nodes_in_use),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_cmd      (s_axis_tuser),
		.in_index    (s_axis_tdata[6:0]),
		.in_rec      (in_rec),
		.nm_we       (nm_we),
		.nm_waddr    (nm_waddr),
		.nm_wdata    (nm_wdata),
		.nm_re       (nm_re),
		.nm_raddr    (nm_raddr),
		.nm_rdata    (nm_rdata),
		.q_we        (q_we),
		.q_waddr     (q_waddr),
		.q_wdata     (q_wdata),
		.q_re        (q_re),
		.q_raddr     (q_raddr),
		.q_rdata     (q_rdata),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

	gfns_node_mem #(
		.MAX_NODES(MAX_NODES)
	) u_node_mem (
		.clk  (clk),
		.we   (nm_we),
		.waddr(nm_waddr),
		.wdata(nm_wdata),
		.re   (nm_re),
		.raddr(nm_raddr),
		.rdata(nm_rdata)
	);

	gfns_visit_queue #(
		.MAX_NODES(MAX_NODES)
	) u_visit_queue (
		.clk  (clk),
		.we   (q_we),
		.waddr(q_waddr),
		.wdata(q_wdata),
		.re   (q_re),
		.raddr(q_raddr),
		.rdata(q_rdata)
	);

	// output register between the search and the result transfer
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_q.distance, out_q.node};

endmodule
